FILE: src/cbf_pkg.sv
`default_nettype none
package cbf_pkg;
   localparam int FILTER_BITS_DEF = 65536;
   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] CNT_MAX = 4'hF;
   localparam int HASH_W = 64;
   localparam int SIZE_W = 17;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [1:0] CMD_ADD = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_TEST = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_TABLE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HASH_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COUNTING_MODE = 2'd2;

   typedef struct packed {
      logic [1:0] command;
      logic [HASH_W-1:0] hash_word_0;
      logic [HASH_W-1:0] hash_word_1;
      logic [HASH_W-1:0] hash_word_2;
      logic [HASH_W-1:0] hash_word_3;
   } req_type;

   typedef struct packed {
      logic present;
      logic status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_MOD, ST_READ, ST_WAIT, ST_WRITE, ST_DONE
   } state_type;

   // start/busy between sequencer and modulo unit
   typedef struct packed {
      logic start;
      logic busy;
   } mod_ctl_type;
endpackage
`default_nettype wire

FILE: src/cbf_mod.sv
`default_nettype none
// restoring remainder, one bit per cycle
module cbf_mod #(
   parameter int IDX_W = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [cbf_pkg::HASH_W-1:0] dividend,
   input  wire logic [IDX_W:0] divisor,
   output logic busy,
   output logic [IDX_W-1:0] remainder
);
   import cbf_pkg::*;
   logic [HASH_W-1:0] q_ff, q_in;
   logic [IDX_W:0] r_ff, r_in;
   logic [6:0] n_ff, n_in;
   logic [IDX_W+1:0] trial;

   always_comb begin
      trial = {r_ff, q_ff[HASH_W-1]};
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      if (start) begin
         q_in = dividend;
         r_in = '0;
         n_in = 7'(HASH_W);
      end else if (n_ff != '0) begin
         q_in = {q_ff[HASH_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) r_in = (IDX_W+1)'(trial - {1'b0, divisor});
         else r_in = trial[IDX_W:0];
         n_in = n_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (reset) n_ff <= '0;
      else n_ff <= n_in;
   end

   assign busy = (n_ff != '0);
   assign remainder = r_ff[IDX_W-1:0];
endmodule
`default_nettype wire

FILE: src/cbf_store.sv
`default_nettype none
// bit and counter memory, one read and one write port, read data registered
module cbf_store #(
   parameter int IDX_W = 16
) (
   input  wire logic clock,
   input  wire logic [IDX_W-1:0] rd_addr,
   output logic [cbf_pkg::CNT_W:0] rd_data,
   input  wire logic wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire logic [cbf_pkg::CNT_W:0] wr_data
);
   import cbf_pkg::*;
   logic [CNT_W:0] mem [0:(1<<IDX_W)-1];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/counting_bloom_filter_top.sv
`default_nettype none
// channel | dir | handshake      | payload
// req     | in  | valid/stall    | command, hash words 0..3
// rsp     | out | valid/stall    | present, status
// csr     | in  | valid/ready    | index, data
// After reset a clearing pass writes every entry, one a cycle, with req stalled and
// csr still taken. Each selected index costs a start, the remainder steps of the
// bit-serial modulo unit, then a read and a write. A test stops at the first clear
// bit; unknown or refused commands go straight to the result without touching memory.
// One item at a time; the next is taken once the result sits in the output register.
module counting_bloom_filter_top #(
   parameter int FILTER_BITS = cbf_pkg::FILTER_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_stall,
   input  wire cbf_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_stall,
   output cbf_pkg::rsp_type rsp_data,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [cbf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [cbf_pkg::CSR_DATA_W-1:0] csr_data
);
   import cbf_pkg::*;
   localparam int IDX_W = $clog2(FILTER_BITS);

   state_type state_ff, state_in;
   logic [SIZE_W-1:0] tsize_ff;
   logic [2:0] hcount_ff;
   logic cmode_ff;
   req_type req_ff;
   logic [1:0] sel_ff, sel_in;
   logic [1:0] last_sel;
   logic [IDX_W-1:0] clr_ff, idx_ff;
   logic all_ff, all_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff;
   logic [IDX_W:0] divisor;
   logic [HASH_W-1:0] word;
   logic mod_busy;
   logic [IDX_W-1:0] mod_rem;
   mod_ctl_type mod_ctl;
   logic [CNT_W:0] rd_data, wr_data;
   logic wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [CNT_W-1:0] cnt;
   logic bit_v;
   logic take;
   logic rsp_free;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tsize_ff <= 17'd65536;
         hcount_ff <= 3'd4;
         cmode_ff <= 1'b1;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TABLE_SIZE: tsize_ff <= csr_data;
            REG_HASH_COUNT: hcount_ff <= csr_data[2:0];
            REG_COUNTING_MODE: cmode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective modulus and hash count
   always_comb begin
      if (tsize_ff == '0) divisor = (IDX_W+1)'(1);
      else if ({15'd0, tsize_ff} > 32'(FILTER_BITS)) divisor = (IDX_W+1)'(FILTER_BITS);
      else divisor = (IDX_W+1)'(tsize_ff);
      if (hcount_ff == 3'd0) last_sel = 2'd0;
      else if (hcount_ff > 3'd4) last_sel = 2'd3;
      else last_sel = 2'(hcount_ff - 3'd1);
   end

   always_comb begin
      case (sel_ff)
         2'd0: word = req_ff.hash_word_0;
         2'd1: word = req_ff.hash_word_1;
         2'd2: word = req_ff.hash_word_2;
         default: word = req_ff.hash_word_3;
      endcase
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE);
   assign take = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_ff == IDX_W'(FILTER_BITS-1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (take) begin
               if (req_data.command == CMD_ADD || req_data.command == CMD_TEST ||
                   (req_data.command == CMD_REMOVE && cmode_ff)) state_in = ST_MOD;
               else state_in = ST_DONE;
            end
         end
         ST_MOD: state_in = ST_READ;
         ST_READ: if (!mod_busy) state_in = ST_WAIT;
         ST_WAIT: state_in = ST_WRITE;
         ST_WRITE: begin
            if (sel_ff == last_sel ||
                (req_ff.command == CMD_TEST && !rd_data[CNT_W])) state_in = ST_DONE;
            else state_in = ST_MOD;
         end
         ST_DONE: if (rsp_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      mod_ctl.start = (state_ff == ST_MOD);
      mod_ctl.busy = mod_busy;
      sel_in = sel_ff;
      all_in = all_ff;
      if (state_ff == ST_IDLE) begin
         sel_in = '0;
         all_in = 1'b1;
      end
      if (state_ff == ST_WRITE) begin
         sel_in = sel_ff + 2'd1;
         if (!rd_data[CNT_W]) all_in = 1'b0;
      end
   end

   cbf_mod #(.IDX_W(IDX_W)) u_mod (
      .clock(clock), .reset(reset), .start(mod_ctl.start), .dividend(word),
      .divisor(divisor), .busy(mod_busy), .remainder(mod_rem)
   );

   // read-modify-write; the next read of any entry follows a whole modulo run
   // after a write, so no forwarding is needed
   always_comb begin
      bit_v = rd_data[CNT_W];
      cnt = rd_data[CNT_W-1:0];
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = rd_data;
      if (state_ff == ST_CLEAR) begin
         wr_en = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == ST_WRITE) begin
         if (req_ff.command == CMD_ADD) begin
            wr_en = 1'b1;
            if (cmode_ff && cnt != CNT_MAX) cnt = cnt + 4'd1;
            wr_data = {1'b1, cnt};
         end else if (req_ff.command == CMD_REMOVE) begin
            wr_en = 1'b1;
            if (cnt != '0 && cnt != CNT_MAX) cnt = cnt - 4'd1;
            if (cnt == '0) bit_v = 1'b0;
            wr_data = {bit_v, cnt};
         end
      end
   end

   cbf_store #(.IDX_W(IDX_W)) u_store (
      .clock(clock), .rd_addr(mod_rem), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   always_ff @(posedge clock) begin
      if (take) req_ff <= req_data;
      if (state_ff == ST_WAIT) idx_ff <= mod_rem;
      sel_ff <= sel_in;
      all_ff <= all_in;
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ff.present <= (req_ff.command == CMD_TEST) && all_ff;
         rsp_ff.status <= (req_ff.command == CMD_REMOVE) && !cmode_ff;
      end
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (state_ff == ST_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef NO_ASSERTIONS
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall) else $error("req taken during clear");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result lost under stall");
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !wr_en) else $error("write while idle");
   a_mod_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT |-> !mod_busy) else $error("index used before ready");
`endif
endmodule
`default_nettype wire
